// ----- design/idq_pkg.sv -----
`default_nettype none

package idq_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 4;
    localparam int ENTRY_W = 5;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ       = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIND       = 3'd4;

    localparam logic [1:0] CELL_HOLD       = 2'd0;
    localparam logic [1:0] CELL_LOAD       = 2'd1;
    localparam logic [1:0] CELL_TAKE_LEFT  = 2'd2;
    localparam logic [1:0] CELL_TAKE_RIGHT = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] data;
    } idq_cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/idq_cell.sv -----
`default_nettype none

module idq_cell
    import idq_pkg::*;
(
    input  wire logic              aclk,
    input  wire idq_cell_ctrl_t    ctrl,
    input  wire logic [DATA_W-1:0] left_value,
    input  wire logic [DATA_W-1:0] right_value,
    output logic      [DATA_W-1:0] value,
    output logic                   match
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;

    always_comb begin
        unique case (ctrl.op)
            CELL_LOAD:       value_next = ctrl.data;
            CELL_TAKE_LEFT:  value_next = left_value;
            CELL_TAKE_RIGHT: value_next = right_value;
            default:         value_next = value_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign match = (value_reg == ctrl.data);

endmodule

`default_nettype wire

// ----- design/indexed_deque_with_search_top.sv -----
// A request is registered into the compare stage, its result then into the
// output register once that is empty or taken by m_ready. No new request is
// taken until the compare stage has passed its request on; it holds one request
// while its match vector is priority-encoded into the output register.
// Reset (aresetn low, synchronous): entry count cleared, compare stage and
// output register emptied; cell contents are not cleared and count as empty.
`default_nettype none

module indexed_deque_with_search_top
    import idq_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic        [KIND_W-1:0] s_kind,
    input  wire logic signed [DATA_W-1:0] s_value,
    input  wire logic        [POS_W-1:0]  s_position,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_ok,
    output logic signed      [DATA_W-1:0] m_read_value,
    output logic             [POS_W-1:0]  m_found_position,
    output logic             [ENTRY_W-1:0] m_entry_count
);

    logic [DATA_W-1:0] cell_value [DEPTH];
    logic [DATA_W-1:0] left_in    [DEPTH];
    logic [DATA_W-1:0] right_in   [DEPTH];
    logic [DEPTH-1:0]  cell_match;
    idq_cell_ctrl_t    cell_ctrl  [DEPTH];

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              stage_valid_reg;
    logic [KIND_W-1:0] stage_kind_reg;
    logic              stage_ok_reg, stage_ok_next;
    logic [DATA_W-1:0] stage_rd_reg, stage_rd_next;
    logic [DEPTH-1:0]  stage_match_reg, stage_match_next;
    logic [CNT_W-1:0]  stage_count_reg;

    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [DATA_W-1:0] out_rd_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [CNT_W-1:0]  out_count_reg;

    logic              in_xfer;
    logic              stage_move;
    logic              is_full;
    logic              is_empty;
    logic              find_ok;
    logic [POS_W-1:0]  find_pos;

    assign s_ready    = !stage_valid_reg;
    assign in_xfer    = s_valid && s_ready;
    assign stage_move = stage_valid_reg && (!out_valid_reg || m_ready);
    assign is_full    = (count_reg == CNT_W'(DEPTH));
    assign is_empty   = (count_reg == '0);

    // neighbor wiring of the cell row: position 0 is the front
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            left_in[i]  = (i == 0) ? '0 : cell_value[(i == 0) ? 0 : i - 1];
            right_in[i] = (i == DEPTH - 1) ? cell_value[i]
                                           : cell_value[(i == DEPTH - 1) ? i : i + 1];
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_ctrl[i].data = s_value;
            cell_ctrl[i].op   = CELL_HOLD;
            if (in_xfer) begin
                case (s_kind)
                    KIND_PUSH_FRONT: begin
                        if (!is_full) begin
                            cell_ctrl[i].op = (i == 0) ? CELL_LOAD : CELL_TAKE_LEFT;
                        end
                    end
                    KIND_PUSH_BACK: begin
                        if (!is_full && (count_reg == CNT_W'(i))) begin
                            cell_ctrl[i].op = CELL_LOAD;
                        end
                    end
                    KIND_POP_FRONT: begin
                        if (!is_empty && (i != DEPTH - 1)) begin
                            cell_ctrl[i].op = CELL_TAKE_RIGHT;
                        end
                    end
                    default: cell_ctrl[i].op = CELL_HOLD;
                endcase
            end
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        idq_cell u_cell (
            .aclk        (aclk),
            .ctrl        (cell_ctrl[g]),
            .left_value  (left_in[g]),
            .right_value (right_in[g]),
            .value       (cell_value[g]),
            .match       (cell_match[g])
        );
    end

    // request decode against the cells as they stand before the transfer
    always_comb begin
        stage_ok_next    = 1'b0;
        stage_rd_next    = '0;
        stage_match_next = '0;
        count_next       = count_reg;
        case (s_kind)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (!is_full) begin
                    stage_ok_next = 1'b1;
                    count_next    = count_reg + CNT_W'(1);
                end
            end
            KIND_POP_FRONT: begin
                if (!is_empty) begin
                    stage_ok_next = 1'b1;
                    stage_rd_next = cell_value[0];
                    count_next    = count_reg - CNT_W'(1);
                end
            end
            KIND_READ: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if ((32'(s_position) == 32'(i)) && (CNT_W'(i) < count_reg)) begin
                        stage_ok_next = 1'b1;
                        stage_rd_next = cell_value[i];
                    end
                end
            end
            KIND_FIND: begin
                for (int i = 0; i < DEPTH; i++) begin
                    stage_match_next[i] = cell_match[i] && (CNT_W'(i) < count_reg);
                end
            end
            default: stage_ok_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg       <= '0;
            stage_valid_reg <= 1'b0;
        end else begin
            if (in_xfer) begin
                count_reg       <= count_next;
                stage_valid_reg <= 1'b1;
            end else if (stage_move) begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            stage_kind_reg  <= s_kind;
            stage_ok_reg    <= stage_ok_next;
            stage_rd_reg    <= stage_rd_next;
            stage_match_reg <= stage_match_next;
            stage_count_reg <= count_next;
        end
    end

    // first match from the front wins
    always_comb begin
        find_ok  = |stage_match_reg;
        find_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (stage_match_reg[i]) begin
                find_pos = POS_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (stage_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_move) begin
            out_ok_reg    <= (stage_kind_reg == KIND_FIND) ? find_ok : stage_ok_reg;
            out_rd_reg    <= stage_rd_reg;
            out_pos_reg   <= find_pos;
            out_count_reg <= stage_count_reg;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_ok             = out_ok_reg;
    assign m_read_value     = out_rd_reg;
    assign m_found_position = out_pos_reg;
    assign m_entry_count    = ENTRY_W'(out_count_reg);

endmodule

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb
    import idq_pkg::*;
();

    localparam int RANDOM_REQUESTS = 550;
    localparam int QUIET_LIMIT     = 2000;
    localparam int KIND_LAST       = (1 << KIND_W) - 1;
    localparam int POS_LAST        = (1 << POS_W) - 1;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_value;
        logic        [POS_W-1:0]  found_position;
        logic        [ENTRY_W-1:0] entry_count;
    } deque_result_t;

    // Shadow copy of the store: predicts one result per accepted request and
    // checks results against the oldest prediction.
    class deque_shadow;
        logic signed [DATA_W-1:0] cells [DEPTH];
        int unsigned              head;
        int unsigned              fill;
        deque_result_t            awaited_results [$];
        int unsigned              failures;

        function new();
            head     = 0;
            fill     = 0;
            failures = 0;
        endfunction

        function logic signed [DATA_W-1:0] entry_at(int unsigned idx);
            return cells[(head + idx) % DEPTH];
        endfunction

        function void note_request(logic [KIND_W-1:0] kind,
                                   logic signed [DATA_W-1:0] value,
                                   logic [POS_W-1:0] pos);
            deque_result_t r;
            r = '0;
            case (kind)
                KIND_PUSH_FRONT: begin
                    if (fill < DEPTH) begin
                        head        = (head == 0) ? DEPTH - 1 : head - 1;
                        cells[head] = value;
                        fill++;
                        r.ok = 1'b1;
                    end
                end
                KIND_PUSH_BACK: begin
                    if (fill < DEPTH) begin
                        cells[(head + fill) % DEPTH] = value;
                        fill++;
                        r.ok = 1'b1;
                    end
                end
                KIND_POP_FRONT: begin
                    if (fill > 0) begin
                        r.read_value = cells[head];
                        head         = (head + 1) % DEPTH;
                        fill--;
                        r.ok = 1'b1;
                    end
                end
                KIND_READ: begin
                    if (pos < fill) begin
                        r.read_value = entry_at(pos);
                        r.ok         = 1'b1;
                    end
                end
                KIND_FIND: begin
                    for (int unsigned i = 0; i < fill; i++) begin
                        if (entry_at(i) == value) begin
                            r.found_position = POS_W'(i);
                            r.ok             = 1'b1;
                            break;
                        end
                    end
                end
                default: ;
            endcase
            r.entry_count = ENTRY_W'(fill);
            awaited_results.push_back(r);
        endfunction

        function void report(string what);
            failures++;
            if (failures <= 10)
                $display("[%0t] %s", $realtime, what);
        endfunction

        function void check_result(deque_result_t got);
            deque_result_t exp;
            if (awaited_results.size() == 0) begin
                report($sformatf("unexpected result ok=%0b rd=%0d fpos=%0d cnt=%0d",
                                 got.ok, got.read_value, got.found_position,
                                 got.entry_count));
                return;
            end
            exp = awaited_results.pop_front();
            if (got !== exp)
                report($sformatf({"result check failed: expected ok=%0b rd=%0d fpos=%0d ",
                                  "cnt=%0d, got ok=%0b rd=%0d fpos=%0d cnt=%0d"},
                                 exp.ok, exp.read_value, exp.found_position,
                                 exp.entry_count, got.ok, got.read_value,
                                 got.found_position, got.entry_count));
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic        [KIND_W-1:0] s_kind;
    logic signed [DATA_W-1:0] s_value;
    logic        [POS_W-1:0]  s_position;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_ok;
    logic signed [DATA_W-1:0] m_read_value;
    logic        [POS_W-1:0]  m_found_position;
    logic        [ENTRY_W-1:0] m_entry_count;

    deque_shadow sb = new();

    int send_idle_pct;
    int recv_stall_pct;
    int stall_left;
    int quiet_cycles;
    int sent_requests;

    indexed_deque_with_search_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_value          (s_value),
        .s_position       (s_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_ok             (m_ok),
        .m_read_value     (m_read_value),
        .m_found_position (m_found_position),
        .m_entry_count    (m_entry_count)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls on m_ready.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    = 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_ready = 1'b1;
            if ($urandom_range(0, 99) < recv_stall_pct)
                stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_ok, m_read_value, m_found_position, m_entry_count});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("indexed_deque_with_search_top: mismatch");
                $finish;
            end
        end
    end

    // Present one request at the falling edge, hold it until the transfer.
    task automatic send_request(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] value,
                                logic [POS_W-1:0] pos);
        if ($urandom_range(0, 99) < send_idle_pct)
            repeat (pick_gap()) @(negedge aclk);
        s_valid    = 1'b1;
        s_kind     = kind;
        s_value    = value;
        s_position = pos;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(kind, value, pos);
        sent_requests++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_for_results();
        while (sb.awaited_results.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Bias toward values already held so finds hit often.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return $urandom_range(0, 6) - 3;
        if (sel < 6 && sb.fill > 0)
            return sb.entry_at($urandom_range(0, sb.fill - 1));
        if (sel == 6) begin
            case ($urandom_range(0, 3))
                0: return {1'b1, {(DATA_W-1){1'b0}}};
                1: return {1'b0, {(DATA_W-1){1'b1}}};
                2: return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if (sb.fill > 0 && $urandom_range(0, 9) < 7)
            return POS_W'($urandom_range(0, sb.fill - 1));
        return POS_W'($urandom_range(0, POS_LAST));
    endfunction

    task automatic push_request();
        send_request($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                     pick_value(), POS_W'($urandom_range(0, POS_LAST)));
    endtask

    task automatic probe_request();
        send_request($urandom_range(0, 1) ? KIND_READ : KIND_FIND,
                     pick_value(), pick_position());
    endtask

    task automatic random_request();
        int sel;
        logic [KIND_W-1:0] kind;
        sel = $urandom_range(0, 99);
        if (sel < 20)      kind = KIND_PUSH_FRONT;
        else if (sel < 40) kind = KIND_PUSH_BACK;
        else if (sel < 55) kind = KIND_POP_FRONT;
        else if (sel < 75) kind = KIND_READ;
        else if (sel < 95) kind = KIND_FIND;
        else               kind = KIND_W'($urandom_range(KIND_FIND + 1, KIND_LAST));
        send_request(kind, pick_value(), pick_position());
    endtask

    initial begin
        int goal;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_kind         = KIND_PUSH_FRONT;
        s_value        = '0;
        s_position     = '0;
        m_ready        = 1'b0;
        stall_left     = 0;
        quiet_cycles   = 0;
        sent_requests  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        goal           = RANDOM_REQUESTS;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Empty store: every request that needs an entry fails.
        send_request(KIND_READ, 32'sd0, '0);
        send_request(KIND_POP_FRONT, 32'sd7, '0);
        send_request(KIND_FIND, 32'sd0, '0);
        send_request(KIND_W'(KIND_FIND + 1), -32'sd1, '1);
        send_request(KIND_W'(KIND_LAST), 32'sd5, 4'd3);
        // Extreme values at both ends.
        send_request(KIND_PUSH_BACK, {1'b0, {(DATA_W-1){1'b1}}}, '0);
        send_request(KIND_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}}, '1);
        send_request(KIND_PUSH_BACK, -32'sd1, '0);
        send_request(KIND_PUSH_BACK, 32'sd0, '0);
        send_request(KIND_READ, 32'sd0, 4'd0);
        send_request(KIND_READ, 32'sd0, 4'd1);
        send_request(KIND_READ, 32'sd0, 4'd3);
        send_request(KIND_READ, 32'sd0, 4'd4);
        send_request(KIND_READ, -32'sd1, '1);
        send_request(KIND_FIND, -32'sd1, '0);
        send_request(KIND_FIND, 32'sd12345, '0);
        send_request(KIND_FIND, {1'b1, {(DATA_W-1){1'b0}}}, '0);
        // Duplicate at the front: find must report the first match.
        send_request(KIND_PUSH_FRONT, -32'sd1, '0);
        send_request(KIND_FIND, -32'sd1, '1);
        send_request(KIND_POP_FRONT, 32'sd0, '0);

        // Fill past full, probe the full store, then drain past empty.
        repeat (DEPTH + 2) push_request();
        repeat (6) probe_request();
        wait_for_results();
        repeat (DEPTH + 2) send_request(KIND_POP_FRONT, pick_value(), pick_position());

        send_idle_pct  = 30;
        recv_stall_pct = 25;
        while (sent_requests < goal) begin
            random_request();
            // Every hundred requests, hold the sender until every result is back.
            if (sent_requests % 100 == 0)
                wait_for_results();
            if (sent_requests == goal / 2) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            if (sent_requests == (goal * 3) / 4) begin
                send_idle_pct  = 10;
                recv_stall_pct = 60;
            end
        end

        wait_for_results();
        repeat (4) @(negedge aclk);
        if (sb.failures == 0 && sb.awaited_results.size() == 0)
            $display("indexed_deque_with_search_top: match");
        else
            $display("indexed_deque_with_search_top: mismatch");
        $finish;
    end
endmodule

// ----- files.f -----
design/idq_pkg.sv
design/idq_cell.sv
design/indexed_deque_with_search_top.sv
verif/tb.sv
